### src/segi_pkg.sv
package segi_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int RADIUS_BITS = 15;
	localparam int RADIUS_RESET = 16;
	localparam int RADIUS_SQ_BITS = 2 * RADIUS_BITS;

	localparam logic ACT_SEGMENT = 1'b0;
	localparam logic ACT_POINT = 1'b1;

endpackage

### src/segi_req_if.sv
interface segi_req_if #(
	parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF
);
	logic valid;
	logic ready;
	logic action;
	logic signed [COORD_BITS-1:0] a_start_x;
	logic signed [COORD_BITS-1:0] a_start_y;
	logic signed [COORD_BITS-1:0] a_end_x;
	logic signed [COORD_BITS-1:0] a_end_y;
	logic signed [COORD_BITS-1:0] b_start_x;
	logic signed [COORD_BITS-1:0] b_start_y;
	logic signed [COORD_BITS-1:0] b_end_x;
	logic signed [COORD_BITS-1:0] b_end_y;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;

	modport source (
		output valid, action, a_start_x, a_start_y, a_end_x, a_end_y,
		output b_start_x, b_start_y, b_end_x, b_end_y, point_x, point_y,
		input ready
	);

	modport sink (
		input valid, action, a_start_x, a_start_y, a_end_x, a_end_y,
		input b_start_x, b_start_y, b_end_x, b_end_y, point_x, point_y,
		output ready
	);
endinterface

### src/segi_rsp_if.sv
interface segi_rsp_if;
	logic valid;
	logic ready;
	logic hit;

	modport source (
		output valid, hit,
		input ready
	);

	modport sink (
		input valid, hit,
		output ready
	);
endinterface

### src/segi_radius_sq.sv
module segi_radius_sq (
	input  logic clk,
	input  logic arst_n,
	input  logic we,
	input  logic [segi_pkg::RADIUS_BITS-1:0] wdata,
	output logic [segi_pkg::RADIUS_SQ_BITS-1:0] radius_sq
);

	localparam logic [segi_pkg::RADIUS_SQ_BITS-1:0] RADIUS_SQ_RESET =
		segi_pkg::RADIUS_SQ_BITS'(segi_pkg::RADIUS_RESET * segi_pkg::RADIUS_RESET);

	logic [segi_pkg::RADIUS_SQ_BITS-1:0] radius_sq_q;

	// The register keeps the squared radius, since only that is ever compared.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_sq_q <= RADIUS_SQ_RESET;
		end else if (we) begin
			radius_sq_q <= segi_pkg::RADIUS_SQ_BITS'(wdata) *
				segi_pkg::RADIUS_SQ_BITS'(wdata);
		end
	end

	assign radius_sq = radius_sq_q;

endmodule

### src/segment_intersection_tester.sv
// Segment intersection tester.
// Items arrive on the req channel: segment A plus either segment B (action 0)
// or a point (action 1). Each item yields exactly one result transfer on the
// rsp channel, carrying hit, in the order the items were taken.
// The node radius for point mode is to be written by the user through cfg_we
// and cfg_wdata while the block is idle (not enforced); it resets to 16.
// The datapath is a six-stage pipeline: differences, cross products, sums,
// range checks with the split squaring products, wide sums, final compare.
// One item can be taken in every cycle while the receiver keeps rsp.ready
// high, so the sustained rate is then one item per cycle.
// Reset empties the pipeline and restores the radius. When the receiver
// holds rsp.ready low, the last stage keeps its result and the stages behind
// it keep filling empty slots; req.ready drops only once every stage holds
// an item, and nothing is dropped or repeated.
module segment_intersection_tester #(
	parameter int COORD_BITS = segi_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [segi_pkg::RADIUS_BITS-1:0] cfg_wdata,
	segi_req_if.sink req,
	segi_rsp_if.source rsp
);

	localparam int DW = COORD_BITS + 1;
	localparam int PW = 2 * COORD_BITS + 2;
	localparam int SW = 2 * COORD_BITS + 3;
	localparam int H = COORD_BITS + 1;
	localparam int CW = 2 * H;
	localparam int RW = segi_pkg::RADIUS_SQ_BITS;
	localparam int XW = 4 * H + RW;

	logic [RW-1:0] radius_sq;

	segi_radius_sq u_radius (
		.clk(clk),
		.arst_n(arst_n),
		.we(cfg_we),
		.wdata(cfg_wdata),
		.radius_sq(radius_sq)
	);

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, en4, en5, en6;

	assign en6 = !v_s6 || rsp.ready;
	assign en5 = !v_s5 || en6;
	assign en4 = !v_s4 || en5;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	// Stage 1: direction vectors. In point mode the B direction is set to the
	// normal of A, so den, tn and un become the squared length, the dot
	// product and the negated cross product of the same datapath.
	logic signed [DW-1:0] dx, dy, ex, ey, wx, wy;
	logic seg_shared, pt_shared;

	always_comb begin
		dx = DW'(req.a_end_x) - DW'(req.a_start_x);
		dy = DW'(req.a_end_y) - DW'(req.a_start_y);
		if (req.action == segi_pkg::ACT_POINT) begin
			ex = -dy;
			ey = dx;
			wx = DW'(req.point_x) - DW'(req.a_start_x);
			wy = DW'(req.point_y) - DW'(req.a_start_y);
		end else begin
			ex = DW'(req.b_end_x) - DW'(req.b_start_x);
			ey = DW'(req.b_end_y) - DW'(req.b_start_y);
			wx = DW'(req.b_start_x) - DW'(req.a_start_x);
			wy = DW'(req.b_start_y) - DW'(req.a_start_y);
		end
		seg_shared =
			(req.a_start_x == req.b_start_x && req.a_start_y == req.b_start_y) ||
			(req.a_end_x == req.b_start_x && req.a_end_y == req.b_start_y) ||
			(req.a_start_x == req.b_end_x && req.a_start_y == req.b_end_y) ||
			(req.a_end_x == req.b_end_x && req.a_end_y == req.b_end_y);
		pt_shared =
			(req.point_x == req.a_start_x && req.point_y == req.a_start_y) ||
			(req.point_x == req.a_end_x && req.point_y == req.a_end_y);
	end

	logic act_s1, excl_s1;
	logic signed [DW-1:0] dx_s1, dy_s1, ex_s1, ey_s1, wx_s1, wy_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			act_s1 <= req.action;
			excl_s1 <= (req.action == segi_pkg::ACT_POINT) ? pt_shared : seg_shared;
			dx_s1 <= dx;
			dy_s1 <= dy;
			ex_s1 <= ex;
			ey_s1 <= ey;
			wx_s1 <= wx;
			wy_s1 <= wy;
		end
	end

	// Stage 2: the six products of the three cross products.
	logic act_s2, excl_s2;
	logic signed [PW-1:0] p0_s2, p1_s2, p2_s2, p3_s2, p4_s2, p5_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			act_s2 <= act_s1;
			excl_s2 <= excl_s1;
			p0_s2 <= PW'(dx_s1) * PW'(ey_s1);
			p1_s2 <= PW'(dy_s1) * PW'(ex_s1);
			p2_s2 <= PW'(wx_s1) * PW'(ey_s1);
			p3_s2 <= PW'(wy_s1) * PW'(ex_s1);
			p4_s2 <= PW'(wx_s1) * PW'(dy_s1);
			p5_s2 <= PW'(wy_s1) * PW'(dx_s1);
		end
	end

	// Stage 3: determinant, both numerators and the cross product magnitude.
	logic signed [SW-1:0] un_pos, un_neg;

	assign un_pos = SW'(p4_s2) - SW'(p5_s2);
	assign un_neg = SW'(p5_s2) - SW'(p4_s2);

	logic act_s3, excl_s3;
	logic signed [SW-1:0] den_s3, tn_s3, un_s3;
	logic [CW-1:0] cmag_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			act_s3 <= act_s2;
			excl_s3 <= excl_s2;
			den_s3 <= SW'(p0_s2) - SW'(p1_s2);
			tn_s3 <= SW'(p2_s2) - SW'(p3_s2);
			un_s3 <= un_pos;
			cmag_s3 <= un_pos[SW-1] ? CW'(un_neg) : CW'(un_pos);
		end
	end

	// Stage 4: parameter range checks and the partial products of
	// cross^2 and radius^2 * length^2.
	logic t_ok, u_ok, pre;
	logic [H-1:0] c_hi, c_lo, l_hi, l_lo;
	logic [CW-1:0] len;

	always_comb begin
		if (den_s3[SW-1]) begin
			t_ok = tn_s3 <= 0 && tn_s3 >= den_s3;
			u_ok = un_s3 <= 0 && un_s3 >= den_s3;
		end else begin
			t_ok = tn_s3 >= 0 && tn_s3 <= den_s3;
			u_ok = un_s3 >= 0 && un_s3 <= den_s3;
		end
		pre = den_s3 != 0 && !excl_s3 && t_ok && (act_s3 == segi_pkg::ACT_POINT || u_ok);
		len = CW'(den_s3);
		c_hi = cmag_s3[CW-1:H];
		c_lo = cmag_s3[H-1:0];
		l_hi = len[CW-1:H];
		l_lo = len[H-1:0];
	end

	logic act_s4, pre_s4;
	logic [2*H-1:0] chh_s4, chl_s4, cll_s4;
	logic [RW+H-1:0] rlh_s4, rll_s4;

	always_ff @(posedge clk) begin
		if (en4) begin
			act_s4 <= act_s3;
			pre_s4 <= pre;
			chh_s4 <= (2 * H)'(c_hi) * (2 * H)'(c_hi);
			chl_s4 <= (2 * H)'(c_hi) * (2 * H)'(c_lo);
			cll_s4 <= (2 * H)'(c_lo) * (2 * H)'(c_lo);
			rlh_s4 <= (RW + H)'(radius_sq) * (RW + H)'(l_hi);
			rll_s4 <= (RW + H)'(radius_sq) * (RW + H)'(l_lo);
		end
	end

	// Stage 5: assemble both sides of the distance compare.
	logic act_s5, pre_s5;
	logic [XW-1:0] lhs_s5, rhs_s5;

	always_ff @(posedge clk) begin
		if (en5) begin
			act_s5 <= act_s4;
			pre_s5 <= pre_s4;
			lhs_s5 <= (XW'(chh_s4) << (2 * H)) + (XW'(chl_s4) << (H + 1)) + XW'(cll_s4);
			rhs_s5 <= (XW'(rlh_s4) << H) + XW'(rll_s4);
		end
	end

	// Stage 6: output register.
	logic hit_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			hit_s6 <= pre_s5 && (act_s5 == segi_pkg::ACT_SEGMENT || lhs_s5 <= rhs_s5);
		end
	end

	assign rsp.valid = v_s6;
	assign rsp.hit = hit_s6;

endmodule
